### design/min_cost_assignment_solver_defines.svh
// Assertion macros for the assignment solver design file.
`ifndef MIN_COST_ASSIGNMENT_SOLVER_DEFINES_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define MCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define MCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MCA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/mca_pkg.sv
// Constants and saturating arithmetic for the assignment solver.
package mca_pkg;
    localparam int SUM_W = 40;
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_PAD  = 2'd2;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Clamp a one-bit-grown sum back into the signed 40-bit range
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] res;
        if (x[SUM_W] != x[SUM_W-1]) begin
            res = x[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            res = x[SUM_W-1:0];
        end
        return res;
    endfunction
endpackage

### design/min_cost_assignment_solver.sv
// Solver top: cost memory, column state arrays and the solve sequencer.
// Load: one cell beat per cycle while idle; non-final cells cause no result.
// Solve: per row phase, each search step scans n columns through the cost
// memory and updates n+1 columns, with n = max(rows, columns); then the
// columns are collected and one result beat is emitted per real row.
// Reset: synchronous, active low; clears control state and config to
// 16 rows, 16 columns, pad cost 0. The cost memory is not cleared.
`include "min_cost_assignment_solver_defines.svh"
module min_cost_assignment_solver
    import mca_pkg::*;
#(
    parameter int MAX_SIZE   = 16,
    parameter int COST_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_row_index,
    input  logic [3:0]  i_column_index,
    input  logic signed [31:0] i_cell_cost,
    input  logic        i_final_cell,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_result_row,
    output logic        o_has_match,
    output logic [3:0]  o_matched_column,
    output logic        o_last_row
);
    localparam int RW = $clog2(MAX_SIZE);
    localparam int IW = $clog2(MAX_SIZE + 1);
    localparam int GW = $clog2(MAX_SIZE + 2);
    localparam int AW = 2 * RW;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam logic signed [63:0] CMAX = (64'sd1 <<< (COST_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_PHASE = 9'b000000100,
        S_SETUP = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_AUG   = 9'b001000000,
        S_FIND  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]         r_rows, r_cols;
    logic signed [31:0] r_pad;

    // cost memory
    logic signed [31:0] r_mem [0:DEPTH-1];
    logic signed [31:0] r_mem_q;
    logic [AW-1:0]      mem_raddr;
    logic               mem_re;

    // column and row state
    logic signed [SUM_W-1:0] r_u    [0:MAX_SIZE];
    logic signed [SUM_W-1:0] r_v    [0:MAX_SIZE];
    logic signed [SUM_W-1:0] r_minv [0:MAX_SIZE];
    logic                    r_mtop [0:MAX_SIZE];
    logic                    r_used [0:MAX_SIZE];
    logic [IW-1:0]           r_own  [0:MAX_SIZE];
    logic [IW-1:0]           r_way  [0:MAX_SIZE];
    logic                    r_fv   [0:MAX_SIZE-1];
    logic [RW-1:0]           r_fc   [0:MAX_SIZE-1];

    logic [IW-1:0] r_n, r_nr, r_nc, r_row, r_cur, r_next, r_c, r_ic, r_owner;
    logic [GW-1:0] r_g;
    logic [RW-1:0] r_k;
    logic signed [SUM_W-1:0] r_delta, r_uown;
    logic          r_dtop, r_iss;

    // scan pipeline
    logic          r_p0_v, r_p1_v;
    logic [IW-1:0] r_p0_c, r_p1_c;
    logic signed [SUM_W-1:0] r_p1_red;

    // output register
    logic          r_ov, r_has;
    logic [3:0]    r_orow, r_ocol;
    logic          r_olast;

    // load-side decode
    logic          in_acc, ld_ok;
    logic [AW-1:0] ld_addr;
    logic [IW-1:0] nr_c, nc_c;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign ld_ok = (32'(i_row_index) < MAX_SIZE) && (32'(i_column_index) < MAX_SIZE);
    assign ld_addr = {RW'(i_row_index), RW'(i_column_index)};
    assign nr_c = (r_rows == 5'd0) ? IW'(1) :
                  (32'(r_rows) > MAX_SIZE) ? IW'(MAX_SIZE) : IW'(r_rows);
    assign nc_c = (r_cols == 5'd0) ? IW'(1) :
                  (32'(r_cols) > MAX_SIZE) ? IW'(MAX_SIZE) : IW'(r_cols);

    // cost memory: one write port, one registered read port
    assign mem_re = (r_state == S_SCAN) && r_iss;
    assign mem_raddr = {RW'(r_owner - IW'(1)), RW'(r_ic - IW'(1))};
    always_ff @(posedge i_clk) begin
        if (in_acc && ld_ok) begin
            r_mem[ld_addr] <= i_cell_cost;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // stage 1: pad select, width clamp, subtract row potential
    logic signed [63:0]      cost64;
    logic signed [SUM_W-1:0] cost40;
    logic                    is_pad;
    assign is_pad = (r_owner > r_nr) || (r_p0_c > r_nc);
    assign cost64 = is_pad ? 64'(r_pad) : 64'(r_mem_q);
    assign cost40 = (COST_WIDTH >= 32) ? SUM_W'(cost64) :
                    (cost64 > CMAX) ? SUM_W'(CMAX) :
                    (cost64 < CMIN) ? SUM_W'(CMIN) : SUM_W'(cost64);

    // stage 2: reduced cost, slack relax, running minimum
    logic signed [SUM_W-1:0] red2, newmin;
    logic                    better, take;
    assign red2 = sat_sum((SUM_W+1)'(r_p1_red) - (SUM_W+1)'(r_v[r_p1_c]));
    assign better = r_mtop[r_p1_c] || (red2 < r_minv[r_p1_c]);
    assign newmin = better ? red2 : r_minv[r_p1_c];
    assign take = r_dtop || (newmin < r_delta);

    // update step operands
    logic [IW-1:0] upd_o;
    assign upd_o = r_own[r_c];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= 5'd16;
            r_cols  <= 5'd16;
            r_pad   <= '0;
            r_ov    <= 1'b0;
            r_p0_v  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_iss   <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROWS: r_rows <= i_cfg_wdata[4:0];
                    REG_COLS: r_cols <= i_cfg_wdata[4:0];
                    REG_PAD:  r_pad  <= i_cfg_wdata;
                    default:  ;
                endcase
            end
            if (r_ov && !i_out_stall && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_final_cell) begin
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    for (int i = 0; i <= MAX_SIZE; i++) begin
                        r_u[i]   <= '0;
                        r_v[i]   <= '0;
                        r_own[i] <= '0;
                        r_way[i] <= '0;
                    end
                    for (int i = 0; i < MAX_SIZE; i++) begin
                        r_fv[i] <= 1'b0;
                    end
                    r_nr  <= nr_c;
                    r_nc  <= nc_c;
                    r_n   <= (nr_c > nc_c) ? nr_c : nc_c;
                    r_row <= IW'(1);
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    for (int i = 0; i <= MAX_SIZE; i++) begin
                        r_mtop[i] <= 1'b1;
                        r_used[i] <= 1'b0;
                    end
                    r_own[0] <= r_row;
                    r_cur <= '0;
                    r_g   <= '0;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_used[r_cur] <= 1'b1;
                    r_owner <= r_own[r_cur];
                    r_uown  <= r_u[r_own[r_cur]];
                    r_dtop  <= 1'b1;
                    r_next  <= '0;
                    r_ic    <= IW'(1);
                    r_iss   <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // issue one memory read per cycle; the pipe drains by itself
                    r_p0_v <= r_iss;
                    r_p0_c <= r_ic;
                    if (r_iss) begin
                        r_ic <= r_ic + IW'(1);
                        if (r_ic == r_n) begin
                            r_iss <= 1'b0;
                        end
                    end
                    r_p1_v   <= r_p0_v;
                    r_p1_c   <= r_p0_c;
                    r_p1_red <= sat_sum((SUM_W+1)'(cost40) - (SUM_W+1)'(r_uown));
                    if (r_p1_v) begin
                        if (!r_used[r_p1_c]) begin
                            if (better) begin
                                r_minv[r_p1_c] <= red2;
                                r_mtop[r_p1_c] <= 1'b0;
                                r_way[r_p1_c]  <= r_cur;
                            end
                            if (take) begin
                                r_delta <= newmin;
                                r_dtop  <= 1'b0;
                                r_next  <= r_p1_c;
                            end
                        end
                        if (r_p1_c == r_n) begin
                            r_c     <= '0;
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (r_next == '0) begin
                        // no reachable column: leave the phase
                        r_g     <= '0;
                        r_state <= S_AUG;
                    end else begin
                        if (r_used[r_c]) begin
                            r_u[upd_o] <= sat_sum((SUM_W+1)'(r_u[upd_o]) +
                                                  (SUM_W+1)'(r_delta));
                            r_v[r_c]   <= sat_sum((SUM_W+1)'(r_v[r_c]) -
                                                  (SUM_W+1)'(r_delta));
                        end else if (!r_mtop[r_c]) begin
                            r_minv[r_c] <= sat_sum((SUM_W+1)'(r_minv[r_c]) -
                                                   (SUM_W+1)'(r_delta));
                        end
                        r_c <= r_c + IW'(1);
                        if (r_c == r_n) begin
                            r_cur <= r_next;
                            if (r_own[r_next] == '0 || 32'(r_g) + 1 > 32'(r_n)) begin
                                r_g     <= '0;
                                r_state <= S_AUG;
                            end else begin
                                r_g     <= r_g + GW'(1);
                                r_state <= S_SETUP;
                            end
                        end
                    end
                end
                S_AUG: begin
                    // walk the augmenting path back to the root
                    if (r_cur == '0 || 32'(r_g) > 32'(r_n)) begin
                        if (r_row == r_n) begin
                            r_c     <= IW'(1);
                            r_state <= S_FIND;
                        end else begin
                            r_row   <= r_row + IW'(1);
                            r_state <= S_PHASE;
                        end
                    end else begin
                        r_own[r_cur] <= r_own[r_way[r_cur]];
                        r_cur <= r_way[r_cur];
                        r_g   <= r_g + GW'(1);
                    end
                end
                S_FIND: begin
                    if (upd_o >= IW'(1) && upd_o <= r_nr && r_c <= r_nc) begin
                        r_fv[RW'(upd_o - IW'(1))] <= 1'b1;
                        r_fc[RW'(upd_o - IW'(1))] <= RW'(r_c - IW'(1));
                    end
                    r_c <= r_c + IW'(1);
                    if (r_c == r_n) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_orow  <= 4'(r_k);
                        r_has   <= r_fv[r_k];
                        r_ocol  <= r_fv[r_k] ? 4'(r_fc[r_k]) : 4'd0;
                        r_olast <= (IW'(r_k) == r_nr - IW'(1));
                        r_k     <= r_k + RW'(1);
                        if (IW'(r_k) == r_nr - IW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_result_row     = r_orow;
    assign o_has_match      = r_has;
    assign o_matched_column = r_ocol;
    assign o_last_row       = r_olast;

    // a new result beat only comes from the emit sequencer
    `MCA_ASSERT_IMP(a_ov_src, i_clk, i_rst_n, $rose(r_ov), $past(r_state) == S_EMIT)
    // scan pipeline is empty outside the column scan
    `MCA_ASSERT_IMP(a_pipe_scan, i_clk, i_rst_n, r_p1_v || r_p0_v, r_state == S_SCAN)
    // a solve always begins by clearing the row and column state
    `MCA_ASSERT_NXT(a_solve_clr, i_clk, i_rst_n, r_state == S_IDLE && in_acc && i_final_cell,
                    r_state == S_CLR)
endmodule
